// ----- hw/rtl/rgbd_pixel_backproject_transform_assert.svh -----
// Assertion helpers used by the RTL file of the back-projection block.
`ifndef RGBD_PIXEL_BACKPROJECT_TRANSFORM_ASSERT_SVH
`define RGBD_PIXEL_BACKPROJECT_TRANSFORM_ASSERT_SVH

// Same-cycle implication, sampled on clk and quiet during reset.
`define RGBD_BPT_ASSERT_NOW(name, pre, post, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error(msg);

// Next-cycle implication, sampled on clk and quiet during reset.
`define RGBD_BPT_ASSERT_NEXT(name, pre, post, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error(msg);

`endif

// ----- hw/rtl/rgbd_bpt_pkg.sv -----
package rgbd_bpt_pkg;

  // Frame limits; pixels outside are dropped.
  localparam int MaxColumns = 1024;
  localparam int MaxRows    = 1024;

  localparam int NumLanes = 3;
  localparam int LaneX    = 0;
  localparam int LaneY    = 1;
  localparam int LaneZ    = 2;

  // Configuration register indexes.
  localparam logic [2:0] CfgQuatW  = 3'd0;
  localparam logic [2:0] CfgQuatX  = 3'd1;
  localparam logic [2:0] CfgQuatY  = 3'd2;
  localparam logic [2:0] CfgQuatZ  = 3'd3;
  localparam logic [2:0] CfgShiftX = 3'd4;
  localparam logic [2:0] CfgShiftY = 3'd5;
  localparam logic [2:0] CfgShiftZ = 3'd6;

  localparam logic signed [15:0] QuatWReset = 16'sd16384;

  // Twice the principal point, so offsets stay integer: 2u - 2cx.
  localparam logic signed [11:0] CenterU2 = 12'sd639;
  localparam logic signed [11:0] CenterV2 = 12'sd479;

  // 1.0 in Q2.28 and the rounding point of the rotation result.
  localparam logic signed [33:0] OneQ28  = 34'sd268435456;
  localparam int                 RotFrac = 28;

  // Each camera coordinate is round(m * 65536 / D). With the common power of
  // two taken out of D this is floor((m * 2^Pre + Half) / Den), exactly.
  localparam logic [17:0] DenX  = 18'd150375;
  localparam logic [17:0] DenY  = 18'd9375;
  localparam logic [17:0] DenZ  = 18'd625;
  localparam logic [17:0] HalfX = 18'd75187;
  localparam logic [17:0] HalfY = 18'd4687;
  localparam logic [17:0] HalfZ = 18'd312;
  localparam int          PreX  = 11;
  localparam int          PreY  = 7;
  localparam int          PreZ  = 13;
  // Reciprocal scale: 2^Rec is above the largest numerator of the lane.
  localparam int          RecX  = 38;
  localparam int          RecY  = 34;
  localparam int          RecZ  = 30;

  localparam logic [20:0] RecipX = 21'((64'd1 << RecX) / 64'(DenX));
  localparam logic [20:0] RecipY = 21'((64'd1 << RecY) / 64'(DenY));
  localparam logic [20:0] RecipZ = 21'((64'd1 << RecZ) / 64'(DenZ));

  localparam logic [2:0][17:0] DivDen   = {DenZ, DenY, DenX};
  localparam logic [2:0][17:0] DivHalf  = {HalfZ, HalfY, HalfX};
  localparam logic [2:0][20:0] DivRecip = {RecipZ, RecipY, RecipX};
  localparam logic [2:0][5:0]  DivPre   = {6'(PreZ), 6'(PreY), 6'(PreX)};
  localparam logic [2:0][5:0]  DivRec   = {6'(RecZ), 6'(RecY), 6'(RecX)};
  localparam logic [2:0][63:0] DivBias  = {
    64'(HalfZ) * 64'(RecipZ),
    64'(HalfY) * 64'(RecipY),
    64'(HalfX) * 64'(RecipX)
  };

  typedef struct packed {
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
  } pix_color_t;

endpackage

// ----- hw/rtl/rgbd_pixel_backproject_transform.sv -----
// Throughput: one item per cycle while out_ready is high; every stage of the ten-stage pipeline advances
// on its own, so bubbles close up and input is taken while a result waits.
// Items with zero depth or outside the frame are accepted and give no result.
// Reset (rst_n, synchronous, active low) empties the pipeline and loads the
// identity pose; a pose write reaches the rotation matrix through the product registers.
`include "rgbd_pixel_backproject_transform_assert.svh"

module rgbd_pixel_backproject_transform #(
  parameter int MaxColumns = rgbd_bpt_pkg::MaxColumns,
  parameter int MaxRows    = rgbd_bpt_pkg::MaxRows
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_wdata,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [9:0]         in_column,
  input  logic [9:0]         in_row,
  input  logic [15:0]        in_depth_raw,
  input  logic [7:0]         in_blue_in,
  input  logic [7:0]         in_green_in,
  input  logic [7:0]         in_red_in,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] out_world_x,
  output logic signed [31:0] out_world_y,
  output logic signed [31:0] out_world_z,
  output logic [7:0]         out_blue_out,
  output logic [7:0]         out_green_out,
  output logic [7:0]         out_red_out
);

  localparam int NumStages = 10;
  localparam int NL        = rgbd_bpt_pkg::NumLanes;

  // ---------------------------------------------------------------------------
  // Pose registers and the derived rotation matrix
  // ---------------------------------------------------------------------------
  logic signed [15:0] quat_w_r, quat_x_r, quat_y_r, quat_z_r;
  logic signed [31:0] shift_r [NL];
  logic signed [31:0] xx_r, yy_r, zz_r, xy_r, xz_r, yz_r, wx_r, wy_r, wz_r;
  logic signed [33:0] rot_r [3][3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      quat_w_r   <= rgbd_bpt_pkg::QuatWReset;
      quat_x_r   <= '0;
      quat_y_r   <= '0;
      quat_z_r   <= '0;
      shift_r[0] <= '0;
      shift_r[1] <= '0;
      shift_r[2] <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        rgbd_bpt_pkg::CfgQuatW:  quat_w_r   <= 16'(cfg_wdata);
        rgbd_bpt_pkg::CfgQuatX:  quat_x_r   <= 16'(cfg_wdata);
        rgbd_bpt_pkg::CfgQuatY:  quat_y_r   <= 16'(cfg_wdata);
        rgbd_bpt_pkg::CfgQuatZ:  quat_z_r   <= 16'(cfg_wdata);
        rgbd_bpt_pkg::CfgShiftX: shift_r[0] <= cfg_wdata;
        rgbd_bpt_pkg::CfgShiftY: shift_r[1] <= cfg_wdata;
        rgbd_bpt_pkg::CfgShiftZ: shift_r[2] <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    xx_r <= quat_x_r * quat_x_r;
    yy_r <= quat_y_r * quat_y_r;
    zz_r <= quat_z_r * quat_z_r;
    xy_r <= quat_x_r * quat_y_r;
    xz_r <= quat_x_r * quat_z_r;
    yz_r <= quat_y_r * quat_z_r;
    wx_r <= quat_w_r * quat_x_r;
    wy_r <= quat_w_r * quat_y_r;
    wz_r <= quat_w_r * quat_z_r;
  end

  always_ff @(posedge clk) begin
    rot_r[0][0] <= rgbd_bpt_pkg::OneQ28 - ((34'(yy_r) + 34'(zz_r)) <<< 1);
    rot_r[0][1] <= (34'(xy_r) - 34'(wz_r)) <<< 1;
    rot_r[0][2] <= (34'(xz_r) + 34'(wy_r)) <<< 1;
    rot_r[1][0] <= (34'(xy_r) + 34'(wz_r)) <<< 1;
    rot_r[1][1] <= rgbd_bpt_pkg::OneQ28 - ((34'(xx_r) + 34'(zz_r)) <<< 1);
    rot_r[1][2] <= (34'(yz_r) - 34'(wx_r)) <<< 1;
    rot_r[2][0] <= (34'(xz_r) - 34'(wy_r)) <<< 1;
    rot_r[2][1] <= (34'(yz_r) + 34'(wx_r)) <<< 1;
    rot_r[2][2] <= rgbd_bpt_pkg::OneQ28 - ((34'(xx_r) + 34'(yy_r)) <<< 1);
  end

  // ---------------------------------------------------------------------------
  // Pipeline flow control: a stage loads when it is empty or its item moves on.
  // ---------------------------------------------------------------------------
  logic [NumStages:1] vld_r;
  logic [NumStages:1] adv;
  logic               keep;

  always_comb begin
    adv[NumStages] = !vld_r[NumStages] || out_ready;
    for (int k = NumStages - 1; k >= 1; k--) begin
      adv[k] = !vld_r[k] || adv[k+1];
    end
  end

  assign in_ready = adv[1];
  assign keep = (in_depth_raw != '0)
             && (13'(in_column) < 13'(MaxColumns))
             && (13'(in_row) < 13'(MaxRows));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      if (adv[1]) begin
        vld_r[1] <= in_valid && keep;
      end
      for (int k = 2; k <= NumStages; k++) begin
        if (adv[k]) begin
          vld_r[k] <= vld_r[k-1];
        end
      end
    end
  end

  rgbd_bpt_pkg::pix_color_t col_r [1:NumStages];

  always_ff @(posedge clk) begin
    if (adv[1]) begin
      col_r[1] <= '{blue: in_blue_in, green: in_green_in, red: in_red_in};
    end
    for (int k = 2; k <= NumStages; k++) begin
      if (adv[k]) begin
        col_r[k] <= col_r[k-1];
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 1: pixel offsets from the principal point (doubled), as magnitude
  // and sign. The z lane uses an offset of one.
  // ---------------------------------------------------------------------------
  logic signed [11:0] off_u, off_v;
  logic [10:0]        s1_omag_r [NL];
  logic               s1_neg_r  [NL];
  logic [15:0]        s1_depth_r;

  assign off_u = $signed({1'b0, in_column, 1'b0}) - rgbd_bpt_pkg::CenterU2;
  assign off_v = rgbd_bpt_pkg::CenterV2 - $signed({1'b0, in_row, 1'b0});

  always_ff @(posedge clk) begin
    if (adv[1]) begin
      s1_omag_r[rgbd_bpt_pkg::LaneX] <= off_u[11] ? 11'(-off_u) : 11'(off_u);
      s1_neg_r[rgbd_bpt_pkg::LaneX]  <= off_u[11];
      s1_omag_r[rgbd_bpt_pkg::LaneY] <= off_v[11] ? 11'(-off_v) : 11'(off_v);
      s1_neg_r[rgbd_bpt_pkg::LaneY]  <= off_v[11];
      s1_omag_r[rgbd_bpt_pkg::LaneZ] <= 11'd1;
      s1_neg_r[rgbd_bpt_pkg::LaneZ]  <= 1'b0;
      s1_depth_r                     <= in_depth_raw;
    end
  end

  // ---------------------------------------------------------------------------
  // Stages 2 to 6: depth product, then rounded division by a constant through a reciprocal.
  // The reciprocal quotient is low by at most one; the remainder, known to be
  // below twice the divisor, is exact in its low bits and fixes that.
  // ---------------------------------------------------------------------------
  logic [26:0]        s2_mag_r  [NL];
  logic               s2_neg_r  [NL];
  logic [47:0]        s3_prod_r [NL];
  logic [18:0]        s3_alo_r  [NL];
  logic               s3_neg_r  [NL];
  logic [20:0]        s4_q0_r   [NL];
  logic [18:0]        s4_alo_r  [NL];
  logic               s4_neg_r  [NL];
  logic [20:0]        s5_q0_r   [NL];
  logic [18:0]        s5_qb_r   [NL];
  logic [18:0]        s5_alo_r  [NL];
  logic               s5_neg_r  [NL];
  logic signed [21:0] s6_p_r    [NL];

  always_ff @(posedge clk) begin
    for (int l = 0; l < NL; l++) begin
      if (adv[2]) begin
        s2_mag_r[l] <= 27'(s1_omag_r[l]) * 27'(s1_depth_r);
        s2_neg_r[l] <= s1_neg_r[l];
      end
      if (adv[3]) begin
        s3_prod_r[l] <= 48'(s2_mag_r[l]) * 48'(rgbd_bpt_pkg::DivRecip[l]);
        s3_alo_r[l]  <= 19'((48'(s2_mag_r[l]) << rgbd_bpt_pkg::DivPre[l])
                            + 48'(rgbd_bpt_pkg::DivHalf[l]));
        s3_neg_r[l]  <= s2_neg_r[l];
      end
      if (adv[4]) begin
        s4_q0_r[l]  <= 21'(((64'(s3_prod_r[l]) << rgbd_bpt_pkg::DivPre[l])
                            + rgbd_bpt_pkg::DivBias[l]) >> rgbd_bpt_pkg::DivRec[l]);
        s4_alo_r[l] <= s3_alo_r[l];
        s4_neg_r[l] <= s3_neg_r[l];
      end
      if (adv[5]) begin
        s5_qb_r[l]  <= 19'(39'(s4_q0_r[l]) * 39'(rgbd_bpt_pkg::DivDen[l]));
        s5_q0_r[l]  <= s4_q0_r[l];
        s5_alo_r[l] <= s4_alo_r[l];
        s5_neg_r[l] <= s4_neg_r[l];
      end
    end
  end

  logic [18:0]        rem     [NL];
  logic [20:0]        quo     [NL];
  logic signed [21:0] quo_s   [NL];

  always_comb begin
    for (int l = 0; l < NL; l++) begin
      rem[l]   = s5_alo_r[l] - s5_qb_r[l];
      quo[l]   = s5_q0_r[l] + 21'(rem[l] >= 19'(rgbd_bpt_pkg::DivDen[l]));
      quo_s[l] = $signed({1'b0, quo[l]});
    end
  end

  always_ff @(posedge clk) begin
    if (adv[6]) begin
      for (int l = 0; l < NL; l++) begin
        s6_p_r[l] <= s5_neg_r[l] ? -quo_s[l] : quo_s[l];
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stages 7 to 10: rotation, rounding out of Q2.28, translation, saturation.
  // ---------------------------------------------------------------------------
  logic signed [55:0] s7_term_r [3][3];
  logic signed [55:0] s8_acc_r  [NL];
  logic [27:0]        s9_rmag_r [NL];
  logic               s9_neg_r  [NL];
  logic signed [31:0] s10_world_r [NL];

  always_ff @(posedge clk) begin
    if (adv[7]) begin
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          s7_term_r[i][j] <= 56'(rot_r[i][j]) * 56'(s6_p_r[j]);
        end
      end
    end
    if (adv[8]) begin
      for (int i = 0; i < NL; i++) begin
        s8_acc_r[i] <= s7_term_r[i][0] + s7_term_r[i][1] + s7_term_r[i][2];
      end
    end
  end

  logic [54:0] acc_mag [NL];

  always_comb begin
    for (int i = 0; i < NL; i++) begin
      acc_mag[i] = s8_acc_r[i][55] ? 55'(-s8_acc_r[i]) : 55'(s8_acc_r[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (adv[9]) begin
      for (int i = 0; i < NL; i++) begin
        // Round half away from zero on the magnitude.
        s9_rmag_r[i] <= 28'((acc_mag[i] + (55'd1 << (rgbd_bpt_pkg::RotFrac - 1)))
                            >> rgbd_bpt_pkg::RotFrac);
        s9_neg_r[i]  <= s8_acc_r[i][55];
      end
    end
  end

  logic signed [28:0] rot_s   [NL];
  logic signed [33:0] wsum    [NL];
  logic signed [31:0] wsat    [NL];

  always_comb begin
    for (int i = 0; i < NL; i++) begin
      rot_s[i] = s9_neg_r[i] ? -$signed({1'b0, s9_rmag_r[i]})
                             : $signed({1'b0, s9_rmag_r[i]});
      wsum[i]  = 34'(rot_s[i]) + 34'(shift_r[i]);
      if (wsum[i][33:31] == 3'b000 || wsum[i][33:31] == 3'b111) begin
        wsat[i] = 32'(wsum[i]);
      end else if (wsum[i][33]) begin
        wsat[i] = {1'b1, 31'd0};
      end else begin
        wsat[i] = {1'b0, {31{1'b1}}};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv[10]) begin
      for (int i = 0; i < NL; i++) begin
        s10_world_r[i] <= wsat[i];
      end
    end
  end

  assign out_valid     = vld_r[NumStages];
  assign out_world_x   = s10_world_r[rgbd_bpt_pkg::LaneX];
  assign out_world_y   = s10_world_r[rgbd_bpt_pkg::LaneY];
  assign out_world_z   = s10_world_r[rgbd_bpt_pkg::LaneZ];
  assign out_blue_out  = col_r[NumStages].blue;
  assign out_green_out = col_r[NumStages].green;
  assign out_red_out   = col_r[NumStages].red;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  `RGBD_BPT_ASSERT_NOW(a_ready_when_out_empty, !vld_r[NumStages], in_ready, "input refused")
  `RGBD_BPT_ASSERT_NOW(a_full_blocks_input, (&vld_r) && !out_ready, !in_ready, "taken when full")
  `RGBD_BPT_ASSERT_NEXT(a_zero_depth_dropped, in_valid && in_ready && !keep, !vld_r[1], "item kept")
  `RGBD_BPT_ASSERT_NEXT(a_stall_holds_item, vld_r[6] && !adv[6], vld_r[6] && $stable(s6_p_r[0]), "stall lost")

endmodule
